// ----- hw/rtl/lbfit_pkg.sv -----
// Shared types and codes for the letterbox render-rectangle fit block.
// Holds the sequencer states, register indexes and divider handshake structs.
// No dependencies.
package lbfit_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FIT_SEL,
		ST_MUL_SAR,
		ST_DIV_SAR,
		ST_WAIT_SAR,
		ST_MUL_A,
		ST_MUL_B,
		ST_CMP,
		ST_WAIT_FIT,
		ST_PLACE,
		ST_OUT
	} lbfit_state_t;

	typedef enum logic [2:0] {
		REG_VIDEO_WIDTH   = 3'd0,
		REG_VIDEO_HEIGHT  = 3'd1,
		REG_ASPECT_WIDTH  = 3'd2,
		REG_ASPECT_HEIGHT = 3'd3,
		REG_ROTATE        = 3'd4,
		REG_SAR_NUM       = 3'd5,
		REG_SAR_DEN       = 3'd6
	} lbfit_reg_t;

	typedef struct packed {
		logic start;
		logic sar_mode;
	} lbfit_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lbfit_div_stat_t;

endpackage

// ----- hw/rtl/lbfit_zoom_chk.sv -----
// Zoom rectangle clamp and alignment against the video extent.
// Combinational; honors odd quarter turns. Uses no package items.
module lbfit_zoom_chk #(
	parameter int CB = 13
) (
	input  logic                 rot,
	input  logic [CB-1:0]        ext_w,
	input  logic [CB-1:0]        ext_h,
	input  logic signed [CB:0]   zin_l,
	input  logic signed [CB:0]   zin_t,
	input  logic signed [CB:0]   zin_r,
	input  logic signed [CB:0]   zin_b,
	output logic signed [CB:0]   zout_l,
	output logic signed [CB:0]   zout_t,
	output logic signed [CB:0]   zout_r,
	output logic signed [CB:0]   zout_b
);
	logic signed [CB:0] lim_r, lim_b, l, t, r, b;

	always_comb begin
		lim_r = rot ? $signed({1'b0, ext_h}) : $signed({1'b0, ext_w});
		lim_b = rot ? $signed({1'b0, ext_w}) : $signed({1'b0, ext_h});
		l = zin_l;
		t = zin_t;
		r = zin_r;
		b = zin_b;
		// empty zoom selects the whole picture
		if (zin_r == '0 || zin_b == '0) begin
			l = '0;
			t = '0;
			r = lim_r;
			b = lim_b;
		end
		if (l < 0) l = '0;
		if (t < 0) t = '0;
		if (r > lim_r) r = lim_r;
		if (b > lim_b) b = lim_b;
		zout_l = {l[CB:2], 2'b00};
		zout_t = {t[CB:1], 1'b0};
		zout_r = {r[CB:2], 2'b00};
		zout_b = {b[CB:1], 1'b0};
	end
endmodule

// ----- hw/rtl/lbfit_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on lbfit_pkg for its control and status structs.
module lbfit_div #(
	parameter int CB = 13,
	parameter int FW = 29,
	parameter int NW = 42
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lbfit_pkg::lbfit_div_ctl_t  ctl,
	input  logic [NW-1:0]           dividend,
	input  logic [FW-1:0]           divisor,
	output logic [FW-1:0]           quotient,
	output lbfit_pkg::lbfit_div_stat_t stat
);
	localparam int CW = $clog2(FW + 1);

	logic [FW-1:0] rem_q, quo_q, dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [FW:0]   trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[FW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.sar_mode ? CW'(FW) : CW'(CB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dsr_q <= divisor;
			if (ctl.sar_mode) begin
				rem_q <= '0;
				quo_q <= dividend[FW-1:0];
			end else begin
				// quotient fits CB bits, so the upper dividend part is below the divisor
				rem_q <= dividend[NW-1:CB];
				quo_q <= {dividend[CB-1:0], {(FW-CB){1'b0}}};
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[FW-1:0] : trial[FW-1:0];
			quo_q <= {quo_q[FW-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- hw/rtl/letterbox_render_rect_fit.sv -----
// Letterbox render-rectangle fit, top level: sequencer, shared multiplier, registers.
// A same-size zoom or an error in format goes straight to the result; a full layout
// multiplies, compares and divides, and with a non-square sample aspect and no forced
// aspect first scales the zoom width in the one-bit-per-cycle shared divider.
// Throughput: one request at a time; in_ready is high only in idle.
// Reset clears configuration to 0,0,1,1,0,0,0 and zoom, render and extent to zero.
module letterbox_render_rect_fit #(
	parameter int COORD_BITS = 13,
	parameter int RATIO_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_wen,
	input  logic [2:0]                  cfg_index,
	input  logic [((COORD_BITS > RATIO_BITS) ? COORD_BITS : RATIO_BITS)-1:0] cfg_data,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic [COORD_BITS-1:0]       view_left,
	input  logic [COORD_BITS-1:0]       view_top,
	input  logic [COORD_BITS-1:0]       view_right,
	input  logic [COORD_BITS-1:0]       view_bottom,
	input  logic signed [COORD_BITS:0]  zoom_in_left,
	input  logic signed [COORD_BITS:0]  zoom_in_top,
	input  logic signed [COORD_BITS:0]  zoom_in_right,
	input  logic signed [COORD_BITS:0]  zoom_in_bottom,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [COORD_BITS:0]  zoom_left,
	output logic signed [COORD_BITS:0]  zoom_top,
	output logic signed [COORD_BITS:0]  zoom_right,
	output logic signed [COORD_BITS:0]  zoom_bottom,
	output logic [COORD_BITS-1:0]       render_left,
	output logic [COORD_BITS-1:0]       render_top,
	output logic [COORD_BITS-1:0]       render_right,
	output logic [COORD_BITS-1:0]       render_bottom,
	output logic                        layout_done,
	output logic                        layout_error
);
	localparam int CB = COORD_BITS;
	localparam int RB = RATIO_BITS;
	localparam int MB = (CB > RB) ? CB : RB;  // multiplier B operand
	localparam int FW = CB + RB;              // fitted zoom width after sample aspect
	localparam int PW = FW + MB;              // product width
	localparam int NW = CB + FW;              // divider dividend width

	lbfit_pkg::lbfit_state_t state_q, state_d;

	// configuration registers
	logic [CB-1:0] vid_w_q, vid_h_q;
	logic [RB-1:0] asp_w_q, asp_h_q, sar_n_q, sar_d_q;
	logic [1:0]    rot_q;

	// stored state
	logic signed [CB:0] zl_q, zt_q, zr_q, zb_q;
	logic [CB-1:0]      rl_q, rt_q, rr_q, rb_q;
	logic [CB-1:0]      ext_w_q, ext_h_q;

	// captured request
	logic               func_q;
	logic [CB-1:0]      vl_q, vt_q, vr_q, vb_q;
	logic signed [CB:0] nl_q, nt_q, nr_q, nb_q;

	// fit datapath
	logic [FW-1:0] zw_q, zh_q;
	logic [CB-1:0] w_q, h_q;
	logic [PW-1:0] pa_q, pb_q;
	logic          br_ge_q;
	logic          done_q, err_q;

	// zoom checker hookup
	logic               use_cfg_ext;
	logic [CB-1:0]      chk_ew, chk_eh;
	logic signed [CB:0] src_l, src_t, src_r, src_b;
	logic signed [CB:0] ck_l, ck_t, ck_r, ck_b;

	// misc combinational
	logic               same_size, no_fmt, forced, sar_sq;
	logic [CB-1:0]      vw, vh;
	logic signed [CB+1:0] dx, dy;
	logic [CB-1:0]      dxc, dyc;
	logic [FW-1:0]      mul_a;
	logic [MB-1:0]      mul_b;
	logic [PW-1:0]      mul_p;
	logic               br_ge, zero_div;
	logic [CB:0]        pl, pt, pr, pbt;

	// divider
	lbfit_pkg::lbfit_div_ctl_t  div_ctl;
	lbfit_pkg::lbfit_div_stat_t div_stat;
	logic [NW-1:0]              div_dvd;
	logic [FW-1:0]              div_dsr, div_quo;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vid_w_q <= '0;
			vid_h_q <= '0;
			asp_w_q <= RB'(1);
			asp_h_q <= RB'(1);
			rot_q   <= '0;
			sar_n_q <= '0;
			sar_d_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				lbfit_pkg::REG_VIDEO_WIDTH:   vid_w_q <= cfg_data[CB-1:0];
				lbfit_pkg::REG_VIDEO_HEIGHT:  vid_h_q <= cfg_data[CB-1:0];
				lbfit_pkg::REG_ASPECT_WIDTH:  asp_w_q <= cfg_data[RB-1:0];
				lbfit_pkg::REG_ASPECT_HEIGHT: asp_h_q <= cfg_data[RB-1:0];
				lbfit_pkg::REG_ROTATE:        rot_q   <= cfg_data[1:0];
				lbfit_pkg::REG_SAR_NUM:       sar_n_q <= cfg_data[RB-1:0];
				lbfit_pkg::REG_SAR_DEN:       sar_d_q <= cfg_data[RB-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- combinational helpers ----------------
	// same size is judged on the raw new zoom against the stored one
	assign same_size = (($signed({nr_q[CB], nr_q}) - $signed({nl_q[CB], nl_q})) ==
	                    ($signed({zr_q[CB], zr_q}) - $signed({zl_q[CB], zl_q}))) &&
	                   (($signed({nb_q[CB], nb_q}) - $signed({nt_q[CB], nt_q})) ==
	                    ($signed({zb_q[CB], zb_q}) - $signed({zt_q[CB], zt_q})));
	assign no_fmt    = (vid_w_q == '0) || (vid_h_q == '0);
	assign forced    = (asp_w_q != RB'(1)) || (asp_h_q != RB'(1));
	assign sar_sq    = (sar_n_q <= RB'(1)) && (sar_d_q <= RB'(1));

	// inverted view gives zero size
	assign vw = (vr_q > vl_q) ? (vr_q - vl_q) : '0;
	assign vh = (vb_q > vt_q) ? (vb_q - vt_q) : '0;

	// zoom source: new rectangle for a zoom request, stored one for relayout
	assign src_l = func_q ? zl_q : nl_q;
	assign src_t = func_q ? zt_q : nt_q;
	assign src_r = func_q ? zr_q : nr_q;
	assign src_b = func_q ? zb_q : nb_q;

	// a layout loads the extent from the size registers before clamping
	assign use_cfg_ext = func_q || !same_size;
	assign chk_ew = use_cfg_ext ? vid_w_q : ext_w_q;
	assign chk_eh = use_cfg_ext ? vid_h_q : ext_h_q;

	lbfit_zoom_chk #(.CB(CB)) u_zoom_chk (
		.rot    (rot_q[0]),
		.ext_w  (chk_ew),
		.ext_h  (chk_eh),
		.zin_l  (src_l),
		.zin_t  (src_t),
		.zin_r  (src_r),
		.zin_b  (src_b),
		.zout_l (ck_l),
		.zout_t (ck_t),
		.zout_r (ck_r),
		.zout_b (ck_b)
	);

	// zoom shape from the clamped rectangle; negative size counts as zero
	assign dx  = $signed({zr_q[CB], zr_q}) - $signed({zl_q[CB], zl_q});
	assign dy  = $signed({zb_q[CB], zb_q}) - $signed({zt_q[CB], zt_q});
	assign dxc = (dx < 0) ? '0 : dx[CB-1:0];
	assign dyc = (dy < 0) ? '0 : dy[CB-1:0];

	// shared multiplier: operands picked by the sequencer
	always_comb begin
		mul_a = zw_q;
		mul_b = MB'(h_q);
		case (state_q)
			lbfit_pkg::ST_MUL_SAR: begin
				mul_a = zw_q;
				mul_b = MB'(sar_n_q);
			end
			lbfit_pkg::ST_MUL_B: begin
				mul_a = zh_q;
				mul_b = MB'(w_q);
			end
			default: ;
		endcase
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// fit branch: zw*h >= zh*w shrinks height, else width
	assign br_ge    = pa_q >= pb_q;
	assign zero_div = br_ge ? (zw_q == '0) : (zh_q == '0);

	always_comb begin
		if (state_q == lbfit_pkg::ST_DIV_SAR) begin
			div_dvd = pa_q[NW-1:0];
			div_dsr = (sar_d_q == '0) ? FW'(1) : FW'(sar_d_q);
		end else begin
			div_dvd = br_ge ? pb_q[NW-1:0] : pa_q[NW-1:0];
			div_dsr = br_ge ? zw_q : zh_q;
		end
	end

	lbfit_div #(.CB(CB), .FW(FW), .NW(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// center in the view, then align left/right to 4 and top/bottom to 2
	assign pl  = {1'b0, vl_q} + (CB+1)'((vw - w_q) >> 1);
	assign pt  = {1'b0, vt_q} + (CB+1)'((vh - h_q) >> 1);
	assign pr  = pl + {1'b0, w_q};
	assign pbt = pt + {1'b0, h_q};

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lbfit_pkg::ST_IDLE:
				if (in_valid) state_d = lbfit_pkg::ST_DECIDE;
			lbfit_pkg::ST_DECIDE:
				if ((!func_q && same_size) || no_fmt) state_d = lbfit_pkg::ST_OUT;
				else state_d = lbfit_pkg::ST_FIT_SEL;
			lbfit_pkg::ST_FIT_SEL:
				if (!forced && !sar_sq) state_d = lbfit_pkg::ST_MUL_SAR;
				else state_d = lbfit_pkg::ST_MUL_A;
			lbfit_pkg::ST_MUL_SAR:  state_d = lbfit_pkg::ST_DIV_SAR;
			lbfit_pkg::ST_DIV_SAR:  state_d = lbfit_pkg::ST_WAIT_SAR;
			lbfit_pkg::ST_WAIT_SAR:
				if (div_stat.done) state_d = lbfit_pkg::ST_MUL_A;
			lbfit_pkg::ST_MUL_A:    state_d = lbfit_pkg::ST_MUL_B;
			lbfit_pkg::ST_MUL_B:    state_d = lbfit_pkg::ST_CMP;
			lbfit_pkg::ST_CMP:
				if (zero_div) state_d = lbfit_pkg::ST_OUT;
				else state_d = lbfit_pkg::ST_WAIT_FIT;
			lbfit_pkg::ST_WAIT_FIT:
				if (div_stat.done) state_d = lbfit_pkg::ST_PLACE;
			lbfit_pkg::ST_PLACE:    state_d = lbfit_pkg::ST_OUT;
			lbfit_pkg::ST_OUT:
				if (out_ready) state_d = lbfit_pkg::ST_IDLE;
			default:                state_d = lbfit_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = 1'b0;
		out_valid        = 1'b0;
		div_ctl.start    = 1'b0;
		div_ctl.sar_mode = 1'b0;
		case (state_q)
			lbfit_pkg::ST_IDLE: in_ready = 1'b1;
			lbfit_pkg::ST_DIV_SAR: begin
				div_ctl.start    = 1'b1;
				div_ctl.sar_mode = 1'b1;
			end
			lbfit_pkg::ST_CMP: div_ctl.start = !zero_div;
			lbfit_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lbfit_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// stored rectangles, extent and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zl_q    <= '0;
			zt_q    <= '0;
			zr_q    <= '0;
			zb_q    <= '0;
			rl_q    <= '0;
			rt_q    <= '0;
			rr_q    <= '0;
			rb_q    <= '0;
			ext_w_q <= '0;
			ext_h_q <= '0;
			done_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				lbfit_pkg::ST_DECIDE: begin
					done_q <= 1'b0;
					err_q  <= 1'b0;
					if (!func_q && same_size) begin
						// same size: clamp against the current extent, no layout
						zl_q <= ck_l;
						zt_q <= ck_t;
						zr_q <= ck_r;
						zb_q <= ck_b;
					end else if (no_fmt) begin
						// no format: keep the zoom unclamped
						zl_q  <= src_l;
						zt_q  <= src_t;
						zr_q  <= src_r;
						zb_q  <= src_b;
						err_q <= 1'b1;
					end else begin
						ext_w_q <= vid_w_q;
						ext_h_q <= vid_h_q;
						zl_q    <= ck_l;
						zt_q    <= ck_t;
						zr_q    <= ck_r;
						zb_q    <= ck_b;
					end
				end
				lbfit_pkg::ST_CMP:
					if (zero_div) err_q <= 1'b1;
				lbfit_pkg::ST_PLACE: begin
					rl_q   <= {pl[CB-1:2], 2'b00};
					rt_q   <= {pt[CB-1:1], 1'b0};
					rr_q   <= {pr[CB-1:2], 2'b00};
					rb_q   <= {pbt[CB-1:1], 1'b0};
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// request capture and fit working registers
	always_ff @(posedge clk) begin
		case (state_q)
			lbfit_pkg::ST_IDLE:
				if (in_valid) begin
					func_q <= func;
					vl_q   <= view_left;
					vt_q   <= view_top;
					vr_q   <= view_right;
					vb_q   <= view_bottom;
					nl_q   <= zoom_in_left;
					nt_q   <= zoom_in_top;
					nr_q   <= zoom_in_right;
					nb_q   <= zoom_in_bottom;
				end
			lbfit_pkg::ST_FIT_SEL: begin
				w_q <= vw;
				h_q <= vh;
				if (forced) begin
					zw_q <= FW'(asp_w_q);
					zh_q <= FW'(asp_h_q);
				end else if (rot_q[0]) begin
					zw_q <= FW'(dyc);
					zh_q <= FW'(dxc);
				end else begin
					zw_q <= FW'(dxc);
					zh_q <= FW'(dyc);
				end
			end
			lbfit_pkg::ST_MUL_SAR: pa_q <= mul_p;
			lbfit_pkg::ST_WAIT_SAR:
				if (div_stat.done) zw_q <= div_quo;
			lbfit_pkg::ST_MUL_A: pa_q <= mul_p;
			lbfit_pkg::ST_MUL_B: pb_q <= mul_p;
			lbfit_pkg::ST_CMP:   br_ge_q <= br_ge;
			lbfit_pkg::ST_WAIT_FIT:
				if (div_stat.done) begin
					// hold the side that was not fitted
					if (br_ge_q) h_q <= div_quo[CB-1:0];
					else w_q <= div_quo[CB-1:0];
				end
			default: ;
		endcase
	end

	assign zoom_left     = zl_q;
	assign zoom_top      = zt_q;
	assign zoom_right    = zr_q;
	assign zoom_bottom   = zb_q;
	assign render_left   = rl_q;
	assign render_top    = rt_q;
	assign render_right  = rr_q;
	assign render_bottom = rb_q;
	assign layout_done   = done_q;
	assign layout_error  = err_q;
endmodule
